[hw/rtl/crosspoint_switch_matrix_controller_defines.svh]
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller: assertion macros
// Concurrent checks that compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CROSSPOINT_SWITCH_MATRIX_CONTROLLER_DEFINES_SVH
`define CROSSPOINT_SWITCH_MATRIX_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define CSMC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csmc assertion failed");
`define CSMC_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("csmc forbidden condition");
`else
`define CSMC_ASSERT(lbl, clk, rst, prop)
`define CSMC_NEVER(lbl, clk, rst, expr)
`endif

`endif

[hw/rtl/csmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller package
// Field widths, opcodes, port groups and controller/datapath interface types.
// ----------------------------------------------------------------------------
package csmc_pkg;

  localparam int OP_W     = 3;
  localparam int PROC_W   = 3;
  localparam int PORT_W   = 4;
  localparam int ROW_W    = 2;
  localparam int XP_W     = 14;
  localparam int CNT_W    = 8;
  localparam int NUM_ROWS = 4;

  localparam int CHANGE_RANGE_DEF = 256;

  // APB
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_MATRIX_TYPE = 1'b0;   // register index, paddr[2]

  // Matrix geometry per type
  localparam logic [PROC_W-1:0] ROWS_T0  = 3'd4;
  localparam logic [PROC_W-1:0] ROWS_T1  = 3'd2;
  localparam logic [PORT_W-1:0] PORTS_T0 = 4'd9;
  localparam logic [PORT_W-1:0] PORTS_T1 = 4'd14;

  // Type 1 port groups
  localparam logic [PORT_W-1:0] TX_LAST     = 4'd4;
  localparam logic [PORT_W-1:0] PORT_UNUSED = 4'd5;
  localparam logic [PORT_W-1:0] RX_LAST     = 4'd9;
  localparam logic [XP_W-1:0]   TX_MASK     = 14'h001F;  // ports 0-4
  localparam logic [XP_W-1:0]   RX_MASK     = 14'h03C0;  // ports 6-9
  localparam logic [XP_W-1:0]   DX_MASK     = 14'h3C00;  // ports 10-13

  typedef enum logic [OP_W-1:0] {
    OP_CONNECT    = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_VERIFY     = 3'd2,
    OP_VALIDATE   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_READ_ROWS  = 3'd5,
    OP_SET_LOCAL  = 3'd6
  } op_t;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_KO = 1'b1;

  typedef struct packed {
    logic             capture;      // latch the input item
    logic             exec_single;  // run command, load one result
    logic             emit_row;     // load read-rows result for row_idx
    logic [ROW_W-1:0] row_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;    // captured command is read rows
    logic last_row;   // row_idx is the last active row
  } dp_stat_t;

endpackage

[hw/rtl/crosspoint_switch_matrix_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller
// An accepted item is captured, then executed in S_EXEC, where its result is loaded.
// A new item is taken only once the last has left execute; read rows loads one
//   result per active row (2 or 4), one per cycle while the output is not stalled.
// A stalled output holds the sequencer in execute until the result is taken.
// Reset (sync, active high): matrix, change counter, local flag, type cleared.
// ----------------------------------------------------------------------------
module crosspoint_switch_matrix_controller #(
  parameter int CHANGE_RANGE = csmc_pkg::CHANGE_RANGE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [csmc_pkg::DATA_W-1:0]   pwdata,
  output logic [csmc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // command input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csmc_pkg::OP_W-1:0]     opcode,
  input  logic [csmc_pkg::PROC_W-1:0]   processor_index,
  input  logic [csmc_pkg::PORT_W-1:0]   port_index,
  input  logic                          local_value,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [csmc_pkg::ROW_W-1:0]    row_number,
  output logic [csmc_pkg::XP_W-1:0]     row_bits,
  output logic [csmc_pkg::CNT_W-1:0]    change_count,
  output logic                          local_mode,
  output logic                          last
);
  import csmc_pkg::*;

  logic     matrix_type;
  logic     reg_sel;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MATRIX_TYPE);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_type <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      matrix_type <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(DATA_W-1){1'b0}}, matrix_type} : '0;

  csmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  csmc_datapath #(
    .CHANGE_RANGE (CHANGE_RANGE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .matrix_type     (matrix_type),
    .opcode          (opcode),
    .processor_index (processor_index),
    .port_index      (port_index),
    .local_value     (local_value),
    .status          (status),
    .row_number      (row_number),
    .row_bits        (row_bits),
    .change_count    (change_count),
    .local_mode      (local_mode),
    .last            (last)
  );

endmodule

[hw/rtl/csmc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix datapath
// Command capture, crosspoint matrix, change counter, local flag, result regs.
// ----------------------------------------------------------------------------
module csmc_datapath #(
  parameter int CHANGE_RANGE = csmc_pkg::CHANGE_RANGE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csmc_pkg::dp_cmd_t             cmd,
  output csmc_pkg::dp_stat_t            stat,
  input  logic                          matrix_type,
  input  logic [csmc_pkg::OP_W-1:0]     opcode,
  input  logic [csmc_pkg::PROC_W-1:0]   processor_index,
  input  logic [csmc_pkg::PORT_W-1:0]   port_index,
  input  logic                          local_value,
  output logic                          status,
  output logic [csmc_pkg::ROW_W-1:0]    row_number,
  output logic [csmc_pkg::XP_W-1:0]     row_bits,
  output logic [csmc_pkg::CNT_W-1:0]    change_count,
  output logic                          local_mode,
  output logic                          last
);
  import csmc_pkg::*;

  localparam logic [CNT_W:0] RANGE_EXT = (CNT_W+1)'(CHANGE_RANGE);

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [PROC_W-1:0] proc_q;
  logic [PORT_W-1:0] port_q;
  logic              lv_q;

  // architectural state
  logic [XP_W-1:0]  xp   [NUM_ROWS];
  logic [CNT_W-1:0] cnt;
  logic             loc;

  logic [XP_W-1:0]  xp_next  [NUM_ROWS];
  logic [CNT_W-1:0] cnt_next;
  logic             loc_next;
  logic             st_next;

  logic [XP_W-1:0]     pmask;
  logic [XP_W-1:0]     pbit;
  logic [NUM_ROWS-1:0] active;
  logic                row_ok;
  logic                port_ok;
  logic                held;
  logic                bad;
  logic                found;
  logic [ROW_W-1:0]    prow;
  logic [ROW_W-1:0]    orow;
  logic [XP_W-1:0]     rsel;
  logic [XP_W-1:0]     lowbit;
  logic [XP_W-1:0]     rv, tx, rx, dx;
  logic [CNT_W:0]      sum1, sum2;
  logic [CNT_W-1:0]    cnt_p1, cnt_p2;

  function automatic logic multi(input logic [XP_W-1:0] v);
    return |(v & (v - XP_W'(1)));
  endfunction

  assign pmask   = matrix_type ? XP_W'((1 << 14) - 1) : XP_W'((1 << 9) - 1);
  assign active  = matrix_type ? 4'b0011 : 4'b1111;
  assign row_ok  = proc_q < (matrix_type ? ROWS_T1 : ROWS_T0);
  assign port_ok = port_q < (matrix_type ? PORTS_T1 : PORTS_T0);
  assign pbit    = XP_W'(1) << port_q;
  assign prow    = proc_q[ROW_W-1:0];
  assign orow    = prow ^ ROW_W'(1);
  assign rsel    = xp[prow] & pmask;
  assign lowbit  = rsel & (~rsel + XP_W'(1));

  // wrapping counter, advanced by one or by two
  assign sum1   = {1'b0, cnt} + (CNT_W+1)'(1);
  assign sum2   = {1'b0, cnt} + (CNT_W+1)'(2);
  assign cnt_p1 = (sum1 >= RANGE_EXT) ? CNT_W'(sum1 - RANGE_EXT) : sum1[CNT_W-1:0];
  assign cnt_p2 = (sum2 >= RANGE_EXT) ? CNT_W'(sum2 - RANGE_EXT) : sum2[CNT_W-1:0];

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (active[i] && ((xp[i] & pbit) != '0)) held = 1'b1;
    end
  end

  always_comb begin
    bad = 1'b0;
    rv  = '0;
    tx  = '0;
    rx  = '0;
    dx  = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      rv = xp[i] & pmask;
      tx = rv & TX_MASK;
      rx = rv & RX_MASK;
      dx = rv & DX_MASK;
      if (active[i]) begin
        if (!matrix_type) begin
          if (multi(rv)) bad = 1'b1;
        end else begin
          if ((dx == '0) && (multi(tx) || multi(rx))) bad = 1'b1;
          if ((dx != '0) && !multi(dx) && ((tx | rx) != '0)) bad = 1'b1;
        end
      end
    end
  end

  always_comb begin
    xp_next  = xp;
    cnt_next = cnt;
    loc_next = loc;
    st_next  = STATUS_OK;
    found    = 1'b0;
    case (op_q)
      OP_CONNECT: begin
        if (!row_ok || !port_ok) begin
          st_next = STATUS_KO;
        end else begin
          cnt_next = cnt_p2;
          if (!matrix_type) begin
            // drop the row's lowest port, then the first row holding the port
            xp_next[prow] = xp[prow] & ~lowbit;
            for (int i = 0; i < NUM_ROWS; i++) begin
              if (!found && ((xp_next[i] & pbit) != '0)) begin
                xp_next[i] = xp_next[i] & ~pbit;
                found      = 1'b1;
              end
            end
            xp_next[prow] = xp_next[prow] | pbit;
          end else if (port_q == PORT_UNUSED) begin
            st_next = STATUS_KO;
          end else begin
            if (port_q <= TX_LAST) begin
              xp_next[prow] = xp[prow] & ~(TX_MASK | DX_MASK);
            end else if (port_q <= RX_LAST) begin
              xp_next[prow] = xp[prow] & ~(RX_MASK | DX_MASK);
            end else begin
              xp_next[prow] = '0;
            end
            xp_next[orow] = xp[orow] & ~pbit;
            xp_next[prow] = xp_next[prow] | pbit;
          end
        end
      end
      OP_DISCONNECT: begin
        if (!port_ok) begin
          st_next = STATUS_KO;
        end else begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            if (active[i]) xp_next[i] = xp[i] & ~pbit;
          end
          cnt_next = cnt_p1;
          st_next  = held ? STATUS_OK : STATUS_KO;
        end
      end
      OP_VERIFY: begin
        st_next = (!port_ok || held) ? STATUS_KO : STATUS_OK;
      end
      OP_VALIDATE: begin
        st_next = bad ? STATUS_KO : STATUS_OK;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_ROWS; i++) xp_next[i] = '0;
        cnt_next = cnt_p1;
      end
      OP_READ_ROWS: begin
        st_next = STATUS_OK;
      end
      OP_SET_LOCAL: begin
        loc_next = lv_q;
        cnt_next = cnt_p1;
      end
      default: begin
        st_next = STATUS_KO;
      end
    endcase
  end

  assign stat.is_read  = (op_q == OP_READ_ROWS);
  assign stat.last_row = (cmd.row_idx == (matrix_type ? ROW_W'(1) : ROW_W'(3)));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ROWS; i++) xp[i] <= '0;
      cnt <= '0;
      loc <= 1'b0;
    end else if (cmd.exec_single) begin
      xp  <= xp_next;
      cnt <= cnt_next;
      loc <= loc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      proc_q <= processor_index;
      port_q <= port_index;
      lv_q   <= local_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec_single) begin
      status       <= st_next;
      row_number   <= '0;
      row_bits     <= '0;
      change_count <= cnt_next;
      local_mode   <= loc_next;
      last         <= 1'b1;
    end else if (cmd.emit_row) begin
      status       <= STATUS_OK;
      row_number   <= cmd.row_idx;
      row_bits     <= xp[cmd.row_idx] & pmask;
      change_count <= cnt;
      local_mode   <= loc;
      last         <= stat.last_row;
    end
  end

endmodule

[hw/rtl/csmc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller FSM
// Sequences capture, execute and row readout; owns the output valid flag.
// ----------------------------------------------------------------------------
`include "crosspoint_switch_matrix_controller_defines.svh"

module csmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csmc_pkg::dp_cmd_t   cmd,
  input  csmc_pkg::dp_stat_t  stat
);
  import csmc_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t           state;
  logic [ROW_W-1:0] row_idx;
  logic             out_free;
  logic             load;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.capture     = in_valid && in_ready;
    cmd.exec_single = 1'b0;
    cmd.emit_row    = 1'b0;
    cmd.row_idx     = row_idx;
    if (state == S_EXEC && out_free) begin
      cmd.exec_single = !stat.is_read;
      cmd.emit_row    = stat.is_read;
    end
  end

  assign load = cmd.exec_single || cmd.emit_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.exec_single) begin
            state <= S_IDLE;
          end else if (cmd.emit_row) begin
            if (stat.last_row) begin
              state   <= S_IDLE;
              row_idx <= '0;
            end else begin
              row_idx <= row_idx + ROW_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSMC_ASSERT(a_accept_to_exec, clk, rst, (in_valid && in_ready) |=> (state == S_EXEC))
  `CSMC_NEVER(a_idle_row_zero, clk, rst, (state == S_IDLE) && (row_idx != '0))
  `CSMC_ASSERT(a_last_row_done, clk, rst, (cmd.emit_row && stat.last_row) |=> (state == S_IDLE))
  `CSMC_NEVER(a_no_overwrite, clk, rst, load && out_valid && !out_ready)

endmodule

[dv/csmc_matrix_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller: scoreboard
// Watches the register port and both item channels, keeps its own copy of the
// matrix, change counter and local flag, and compares every result field.
// ----------------------------------------------------------------------------
module csmc_matrix_checker #(
  parameter int CHANGE_RANGE = csmc_pkg::CHANGE_RANGE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [csmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [csmc_pkg::DATA_W-1:0]   pwdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [csmc_pkg::OP_W-1:0]     opcode,
  input  logic [csmc_pkg::PROC_W-1:0]   processor_index,
  input  logic [csmc_pkg::PORT_W-1:0]   port_index,
  input  logic                          local_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          status,
  input  logic [csmc_pkg::ROW_W-1:0]    row_number,
  input  logic [csmc_pkg::XP_W-1:0]     row_bits,
  input  logic [csmc_pkg::CNT_W-1:0]    change_count,
  input  logic                          local_mode,
  input  logic                          last,
  output int                            mismatches,
  output int                            outstanding
);
  import csmc_pkg::*;

  typedef struct packed {
    logic             status;
    logic [ROW_W-1:0] row;
    logic [XP_W-1:0]  bits;
    logic [CNT_W-1:0] count;
    logic             loc;
    logic             is_last;
  } reply_t;

  reply_t          pending_replies[$];
  logic [XP_W-1:0] xp_rows[NUM_ROWS];
  logic [CNT_W-1:0] change_cnt;
  logic            local_flag;
  logic            mtype;
  int              fail_count = 0;
  int              queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic bump_changes();
    change_cnt = CNT_W'((int'(change_cnt) + 1) % CHANGE_RANGE);
  endtask

  task automatic push_reply(input logic st, input logic [ROW_W-1:0] row,
                            input logic [XP_W-1:0] bits, input logic fin);
    reply_t r;
    r.status  = st;
    r.row     = row;
    r.bits    = bits;
    r.count   = change_cnt;
    r.loc     = local_flag;
    r.is_last = fin;
    pending_replies.push_back(r);
  endtask

  // Applies one command to the shadow matrix and queues the results it causes.
  task automatic run_command(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] pi,
                             input logic [PORT_W-1:0] po, input logic lv);
    int              rows;
    int              ports;
    int              i;
    logic [XP_W-1:0] mask;
    logic [XP_W-1:0] bit_m;
    logic [XP_W-1:0] r;
    logic            st;
    logic            found;
    rows  = mtype ? 2 : 4;
    ports = mtype ? 14 : 9;
    mask  = XP_W'((1 << ports) - 1);
    bit_m = XP_W'(1) << po;
    st    = STATUS_OK;
    found = 1'b0;
    case (op)
      OP_CONNECT: begin
        if (pi >= rows || po >= ports) begin
          st = STATUS_KO;
        end else begin
          if (!mtype) begin
            r = xp_rows[pi] & mask;
            // drop the lowest port the row holds, then the first row holding the port
            if (r != '0) xp_rows[pi] = xp_rows[pi] & ~(r & (~r + XP_W'(1)));
            for (i = 0; i < NUM_ROWS; i++) begin
              if (!found && (xp_rows[i] & bit_m) != '0) begin
                xp_rows[i] = xp_rows[i] & ~bit_m;
                found = 1'b1;
              end
            end
            xp_rows[pi] = xp_rows[pi] | bit_m;
          end else if (po == PORT_UNUSED) begin
            st = STATUS_KO;
          end else begin
            if (po <= TX_LAST) xp_rows[pi] = xp_rows[pi] & ~(TX_MASK | DX_MASK);
            else if (po <= RX_LAST) xp_rows[pi] = xp_rows[pi] & ~(RX_MASK | DX_MASK);
            else xp_rows[pi] = '0;
            xp_rows[pi ^ 1] = xp_rows[pi ^ 1] & ~bit_m;
            xp_rows[pi] = xp_rows[pi] | bit_m;
          end
          bump_changes();
          bump_changes();
        end
      end
      OP_DISCONNECT: begin
        if (po >= ports) begin
          st = STATUS_KO;
        end else begin
          for (i = 0; i < rows; i++) begin
            if ((xp_rows[i] & bit_m) != '0) found = 1'b1;
            xp_rows[i] = xp_rows[i] & ~bit_m;
          end
          bump_changes();
          st = found ? STATUS_OK : STATUS_KO;
        end
      end
      OP_VERIFY: begin
        if (po >= ports) st = STATUS_KO;
        else
          for (i = 0; i < rows; i++)
            if ((xp_rows[i] & bit_m) != '0) st = STATUS_KO;
      end
      OP_VALIDATE: begin
        for (i = 0; i < rows; i++) begin
          r = xp_rows[i] & mask;
          if (!mtype) begin
            if ($countones(r) > 1) st = STATUS_KO;
          end else if ($countones(r & DX_MASK) == 0) begin
            if ($countones(r & TX_MASK) > 1 || $countones(r & RX_MASK) > 1) st = STATUS_KO;
          end else if ($countones(r & DX_MASK) == 1) begin
            if ((r & (TX_MASK | RX_MASK)) != '0) st = STATUS_KO;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < NUM_ROWS; i++) xp_rows[i] = '0;
        bump_changes();
      end
      OP_READ_ROWS: begin
        for (i = 0; i < rows; i++)
          push_reply(STATUS_OK, ROW_W'(i), xp_rows[i] & mask, i == rows - 1);
        return;
      end
      OP_SET_LOCAL: begin
        local_flag = lv;
        bump_changes();
      end
      default: st = STATUS_KO;
    endcase
    push_reply(st, '0, '0, 1'b1);
  endtask

  task automatic check_reply();
    reply_t want;
    if (pending_replies.size() == 0) begin
      report("result with none pending, row_bits", row_bits, 0);
      return;
    end
    want = pending_replies.pop_front();
    if (status !== want.status)        report("status", status, want.status);
    if (row_number !== want.row)       report("row_number", row_number, want.row);
    if (row_bits !== want.bits)        report("row_bits", row_bits, want.bits);
    if (change_count !== want.count)   report("change_count", change_count, want.count);
    if (local_mode !== want.loc)       report("local_mode", local_mode, want.loc);
    if (last !== want.is_last)         report("last", last, want.is_last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ROWS; k++) xp_rows[k] = '0;
      change_cnt = '0;
      local_flag = 1'b0;
      mtype      = 1'b0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) check_reply();
      if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_TYPE)
        mtype = pwdata[0];
      if (in_valid && in_ready)
        run_command(opcode, processor_index, port_index, local_value);
    end
    queued <= pending_replies.size();
  end

endmodule

[dv/tb_crosspoint_switch_matrix_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crosspoint switch matrix controller testbench
// Directed commands for both matrix types and the type change, then random
// phases under bursty input and a stalling receiver; checking in the scoreboard.
// ----------------------------------------------------------------------------
module tb_crosspoint_switch_matrix_controller;
  import csmc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 37;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     opcode;
  logic [PROC_W-1:0]   processor_index;
  logic [PORT_W-1:0]   port_index;
  logic                local_value;
  logic                out_valid;
  logic                out_ready;
  logic                status;
  logic [ROW_W-1:0]    row_number;
  logic [XP_W-1:0]     row_bits;
  logic [CNT_W-1:0]    change_count;
  logic                local_mode;
  logic                last;
  int                  mismatches;
  int                  outstanding;

  logic                cur_type = 1'b0;
  int                  burst_left = 0;
  int                  max_gap = 3;
  int                  cycle_count = 0;

  crosspoint_switch_matrix_controller u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .opcode, .processor_index, .port_index, .local_value,
    .out_valid, .out_ready, .status, .row_number, .row_bits, .change_count,
    .local_mode, .last
  );

  csmc_matrix_checker u_matrix_chk (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .opcode, .processor_index, .port_index, .local_value,
    .out_valid, .out_ready, .status, .row_number, .row_bits, .change_count,
    .local_mode, .last, .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_crosspoint_switch_matrix_controller failed");
    $finish;
  end

  // receiver: switches between full rate, light, heavy and long stalls
  int rx_cycle = 0;
  int rx_mode  = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= (rx_cycle % 7 == 0);
    endcase
  end

  task automatic write_matrix_type(input logic t);
    logic [DATA_W-1:0] wdata;
    wdata    = $urandom();
    wdata[0] = t;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MATRIX_TYPE, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_type = t;
  endtask

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] pi,
                          input logic [PORT_W-1:0] po, input logic lv);
    in_valid        <= 1'b1;
    opcode          <= op;
    processor_index <= pi;
    port_index      <= po;
    local_value     <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, max_gap)) @(posedge clk);
      max_gap    = $urandom_range(1, 8);
      // now and then a long stretch with valid held high
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  task automatic random_cmd();
    logic [OP_W-1:0]   op;
    logic [PROC_W-1:0] pi;
    logic [PORT_W-1:0] po;
    int                sel;
    int                rows;
    int                ports;
    rows  = cur_type ? 2 : 4;
    ports = cur_type ? 14 : 9;
    sel   = $urandom_range(0, 99);
    if (sel < 36)      op = OP_CONNECT;
    else if (sel < 50) op = OP_DISCONNECT;
    else if (sel < 62) op = OP_VERIFY;
    else if (sel < 72) op = OP_VALIDATE;
    else if (sel < 75) op = OP_CLEAR;
    else if (sel < 85) op = OP_READ_ROWS;
    else if (sel < 97) op = OP_SET_LOCAL;
    else               op = OP_UNDEFINED;
    pi = ($urandom_range(0, 6) == 0) ? PROC_W'($urandom_range(0, 7))
                                     : PROC_W'($urandom_range(0, rows - 1));
    po = ($urandom_range(0, 6) == 0) ? PORT_W'($urandom_range(0, 15))
                                     : PORT_W'($urandom_range(0, ports - 1));
    send_cmd(op, pi, po, 1'($urandom_range(0, 1)));
  endtask

  // lets every queued result drain before the next register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid        <= 1'b0;
    opcode          <= OP_CONNECT;
    processor_index <= '0;
    port_index      <= '0;
    local_value     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // four-row type
    write_matrix_type(1'b0);
    send_cmd(OP_CONNECT, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_CONNECT, 3'd3, 4'd8, 1'b0);
    send_cmd(OP_CONNECT, 3'd0, 4'd8, 1'b0);    // port moves rows, row drops port 0
    send_cmd(OP_CONNECT, 3'd4, 4'd0, 1'b0);    // row out of range
    send_cmd(OP_CONNECT, 3'd7, 4'd15, 1'b1);
    send_cmd(OP_CONNECT, 3'd1, 4'd9, 1'b0);    // port out of range
    send_cmd(OP_VERIFY, 3'd0, 4'd8, 1'b0);
    send_cmd(OP_VERIFY, 3'd0, 4'd15, 1'b0);
    send_cmd(OP_VERIFY, 3'd0, 4'd1, 1'b0);
    send_cmd(OP_DISCONNECT, 3'd5, 4'd8, 1'b0);
    send_cmd(OP_DISCONNECT, 3'd0, 4'd8, 1'b0); // nothing held
    send_cmd(OP_READ_ROWS, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_SET_LOCAL, 3'd0, 4'd0, 1'b1);
    send_cmd(OP_UNDEFINED, 3'd7, 4'd15, 1'b1);
    wait_idle();

    // two-row grouped type
    write_matrix_type(1'b1);
    send_cmd(OP_CONNECT, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_CONNECT, 3'd0, 4'd6, 1'b0);
    send_cmd(OP_CONNECT, 3'd1, 4'd0, 1'b0);    // transmitter taken from the other row
    send_cmd(OP_CONNECT, 3'd0, 4'd1, 1'b0);
    send_cmd(OP_CONNECT, 3'd0, 4'd5, 1'b0);    // unused port still counts
    send_cmd(OP_CONNECT, 3'd1, 4'd13, 1'b0);   // duplex clears the row
    send_cmd(OP_VALIDATE, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_READ_ROWS, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_DISCONNECT, 3'd0, 4'd15, 1'b0);
    wait_idle();

    // back to four rows with a row holding two ports
    write_matrix_type(1'b0);
    send_cmd(OP_VALIDATE, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_READ_ROWS, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_CLEAR, 3'd0, 4'd0, 1'b0);
    send_cmd(OP_SET_LOCAL, 3'd0, 4'd0, 1'b0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0)      write_matrix_type(1'b1);
      else if (p == 1) write_matrix_type(1'b0);
      else             write_matrix_type(1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_ITEMS; n++) random_cmd();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_crosspoint_switch_matrix_controller passed");
    else
      $display("tb_crosspoint_switch_matrix_controller failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/csmc_pkg.sv
hw/rtl/csmc_datapath.sv
hw/rtl/csmc_ctrl.sv
hw/rtl/crosspoint_switch_matrix_controller.sv
dv/csmc_matrix_checker.sv
dv/tb_crosspoint_switch_matrix_controller.sv
